// ----- hw/rtl/pirl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared types and constants for the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int KIND_W = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // s_tdata: position, value; zero padded to bytes
    localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    // m_tdata: read_value, length, full_res; zero padded to bytes
    localparam int M_TDATA_W = ((VAL_W + LEN_W + 1 + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic execute;  // apply the latched item, load the result register
    } ctl_cmd_t;

endpackage

// ----- hw/rtl/positional_insert_remove_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_remove_list
// Bounded ordered list of signed 32-bit values with positional insert,
// remove, read and clear; one result per operation.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (low bit up)
//  s_       in   tdata: position[4:0], value[36:5]; tuser: kind[1:0]
//  m_       out  tdata: read_value[31:0], length[36:32], full_res[37];
//                tuser: ok[0]
//  cfg_     in   cfg_wr_en / cfg_wr_data: capacity, no read-back
//
//  Each operation has two steps: one to capture the transfer, one to
//  apply it to the store and load the result register, so a new item is
//  not taken until the last one has been applied.
//  The execute step waits while a prior result is still held on m_.
//  Reset (aresetn low, synchronous) empties the list, zeroes the store and
//  sets capacity to 16.
// ----------------------------------------------------------------------------
module positional_insert_remove_list #(
    parameter int DEPTH = pirl_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pirl_pkg::S_TDATA_W-1:0]     s_tdata,  // position, value
    input  logic [pirl_pkg::KIND_W-1:0]        s_tuser,  // kind
    // result item
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pirl_pkg::M_TDATA_W-1:0]     m_tdata,  // read_value, length, full_res
    output logic [0:0]                         m_tuser,  // ok
    // capacity register
    input  logic                               cfg_wr_en,
    input  logic [pirl_pkg::CAP_W-1:0]         cfg_wr_data
);
    import pirl_pkg::*;

    ctl_cmd_t                cmd;
    logic                    res_ok;
    logic signed [VAL_W-1:0] res_read_value;
    logic [LEN_W-1:0]        res_length;
    logic                    res_full;

    pirl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pirl_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_kind        (s_tuser),
        .in_position    (s_tdata[POS_W-1:0]),
        .in_value       (s_tdata[POS_W+VAL_W-1:POS_W]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_ok         (res_ok),
        .out_read_value (res_read_value),
        .out_length     (res_length),
        .out_full_res   (res_full)
    );

    // pack result, zero fill to byte boundary
    always_comb begin
        m_tdata                          = '0;
        m_tdata[VAL_W-1:0]               = res_read_value;
        m_tdata[VAL_W+LEN_W-1:VAL_W]     = res_length;
        m_tdata[VAL_W+LEN_W]             = res_full;
        m_tuser[0]                       = res_ok;
    end

endmodule

// ----- hw/rtl/pirl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_ctrl
// Handshake controller: captures an item, then executes it once the result
// register is free.
// ----------------------------------------------------------------------------
module pirl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output pirl_pkg::ctl_cmd_t  cmd
);
    import pirl_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result register free or draining this cycle
                if (!m_valid_reg || m_tready) begin
                    cmd.execute  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- hw/rtl/pirl_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_dpath
// List store as a shift-register array, count, capacity register and the
// result register.
// ----------------------------------------------------------------------------
module pirl_dpath #(
    parameter int DEPTH = pirl_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pirl_pkg::ctl_cmd_t               cmd,
    input  logic [pirl_pkg::KIND_W-1:0]      in_kind,
    input  logic [pirl_pkg::POS_W-1:0]       in_position,
    input  logic signed [pirl_pkg::VAL_W-1:0] in_value,
    input  logic                             cfg_wr_en,
    input  logic [pirl_pkg::CAP_W-1:0]       cfg_wr_data,
    output logic                             out_ok,
    output logic signed [pirl_pkg::VAL_W-1:0] out_read_value,
    output logic [pirl_pkg::LEN_W-1:0]       out_length,
    output logic                             out_full_res
);
    import pirl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
                                           : ((POS_W > CAP_W) ? POS_W : CAP_W);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    // latched item
    kind_t                    kind_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [VAL_W-1:0]  val_reg;

    logic signed [VAL_W-1:0]  entries_reg [DEPTH];
    logic signed [VAL_W-1:0]  entries_next [DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CAP_W-1:0]         cap_reg;

    logic                     ok_reg, ok_next;
    logic signed [VAL_W-1:0]  rd_reg, rd_next;
    logic [LEN_W-1:0]         len_reg;
    logic                     full_reg;

    logic [CMP_W-1:0] pos_x, cnt_x, cnt_m1, limit_x, new_cnt_x;
    logic             ins_ok, rem_ok, rd_ok;

    always_comb begin
        pos_x   = CMP_W'(pos_reg);
        cnt_x   = CMP_W'(count_reg);
        cnt_m1  = cnt_x - CMP_W'(1);
        limit_x = (CMP_W'(cap_reg) < DEPTH_C) ? CMP_W'(cap_reg) : DEPTH_C;
        ins_ok  = (cnt_x < limit_x) && (pos_x <= cnt_x);
        rem_ok  = (pos_x < cnt_x);
        rd_ok   = (pos_x < cnt_x);
    end

    // per-entry next value: each slot looks only at its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        localparam logic [CMP_W-1:0] I_C = CMP_W'(i);
        always_comb begin
            entries_next[i] = entries_reg[i];
            case (kind_reg)
                KIND_INSERT: begin
                    if (ins_ok) begin
                        if (I_C == pos_x) begin
                            entries_next[i] = val_reg;
                        end else if (I_C > pos_x && I_C <= cnt_x) begin
                            entries_next[i] = (i > 0) ? entries_reg[(i > 0) ? i - 1 : 0]
                                                      : entries_reg[i];
                        end
                    end
                end
                KIND_REMOVE: begin
                    if (rem_ok) begin
                        if (I_C == cnt_m1) begin
                            entries_next[i] = '0;
                        end else if (I_C >= pos_x && I_C < cnt_m1) begin
                            entries_next[i] = (i < DEPTH - 1)
                                ? entries_reg[(i < DEPTH - 1) ? i + 1 : i]
                                : entries_reg[i];
                        end
                    end
                end
                KIND_CLEAR: begin
                    entries_next[i] = '0;
                end
                default: begin
                    entries_next[i] = entries_reg[i];
                end
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        unique case (kind_reg)
            KIND_INSERT: begin
                ok_next = ins_ok;
                if (ins_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                ok_next = rem_ok;
                if (rem_ok) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_READ: begin
                ok_next = rd_ok;
                if (rd_ok) begin
                    rd_next = entries_reg[IDX_W'(pos_reg)];
                end
            end
            KIND_CLEAR: begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
        new_cnt_x = CMP_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_t'(in_kind);
            pos_reg  <= in_position;
            val_reg  <= in_value;
        end
        if (cmd.execute) begin
            ok_reg   <= ok_next;
            rd_reg   <= rd_next;
            len_reg  <= LEN_W'(count_next);
            full_reg <= (new_cnt_x >= limit_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            for (int k = 0; k < DEPTH; k++) begin
                entries_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.execute) begin
                count_reg <= count_next;
                for (int k = 0; k < DEPTH; k++) begin
                    entries_reg[k] <= entries_next[k];
                end
            end
        end
    end

    assign out_ok         = ok_reg;
    assign out_read_value = rd_reg;
    assign out_length     = len_reg;
    assign out_full_res   = full_reg;

endmodule

// ----- test/positional_insert_remove_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_remove_list_tb
// Self-checking bench for the positional insert/remove list. A mirror of the
// list predicts each result as an operation transfer is taken. Each result
// transfer is compared field by field with the oldest prediction. The run
// covers a directed opening, then random phases under several capacities
// and idle/stall patterns.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_tb;

    import pirl_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int LIMIT_CYCLES = 200000;   // far above the slowest legal run
    localparam int SETTLE       = 4;        // idle wait before a capacity write

    // one predicted or observed result
    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] rd;
        logic [LEN_W-1:0] len;
        logic             full;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Mirror of the list: own copy of the store, count and capacity.
    // note_op() applies a taken operation and queues its result,
    // check_result() pops the oldest queued result and compares.
    // ------------------------------------------------------------------------
    class list_mirror;
        logic [VAL_W-1:0] store [DEPTH];
        int unsigned      count;
        int unsigned      capacity;
        list_result_t     due_results [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      taken;
        int unsigned      ins_ok;
        int unsigned      ins_rej;
        int unsigned      peak;
        int unsigned      full_hits;

        function new();
            foreach (store[i]) store[i] = '0;
            count      = 0;
            capacity   = 32'(CAP_RESET);
            mismatches = 0;
            checked    = 0;
            taken      = 0;
            ins_ok     = 0;
            ins_rej    = 0;
            peak       = 0;
            full_hits  = 0;
        endfunction

        // a capacity above the store size acts as the store size
        function int unsigned limit();
            return (capacity < DEPTH) ? capacity : DEPTH;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = 32'(c);
        endfunction

        function void note_op(kind_t k, int unsigned pos, logic [VAL_W-1:0] val);
            list_result_t r;
            int unsigned  i;
            r = '0;
            taken++;
            case (k)
                KIND_INSERT: begin
                    // rejected when full or past the end; position == count appends
                    if (count < limit() && pos <= count && count < DEPTH) begin
                        for (i = count; i > pos; i--)
                            store[i] = store[i-1];
                        store[pos] = val;
                        count++;
                        r.ok = 1'b1;
                        ins_ok++;
                    end else begin
                        ins_rej++;
                    end
                end
                KIND_REMOVE: begin
                    // shift down, then zero the slot left vacant at the top
                    if (pos < count) begin
                        for (i = pos; i + 1 < count; i++)
                            store[i] = store[i+1];
                        count--;
                        store[count] = '0;
                        r.ok = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (pos < count) begin
                        r.rd = store[pos];
                        r.ok = 1'b1;
                    end
                end
                default: begin
                    foreach (store[j]) store[j] = '0;
                    count = 0;
                    r.ok  = 1'b1;
                end
            endcase
            r.len  = LEN_W'(count);
            r.full = (count >= limit());
            if (count > peak) peak = count;
            if (r.full) full_hits++;
            due_results.push_back(r);
        endfunction

        function void flag(string what, list_result_t e, list_result_t g);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t ERROR %s: exp ok=%0b rd=%h len=%0d full=%0b",
                          " | got ok=%0b rd=%h len=%0d full=%0b"},
                         $time, what, e.ok, e.rd, e.len, e.full,
                         g.ok, g.rd, g.len, g.full);
        endfunction

        function void check_result(list_result_t got);
            list_result_t e;
            if (due_results.size() == 0) begin
                flag("result with no operation outstanding", '0, got);
                return;
            end
            e = due_results.pop_front();
            checked++;
            if (got.ok !== e.ok || got.rd !== e.rd || got.len !== e.len ||
                    got.full !== e.full)
                flag("result mismatch", e, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // position[4:0], value[36:5], pad
    logic [KIND_W-1:0]    s_tuser     = '0;   // kind[1:0]
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // read_value[31:0], length[36:32], full_res[37]
    logic [0:0]           m_tuser;            // ok[0]
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;

    list_mirror  mirror;
    int unsigned tx_idle_pct  = 0;   // chance per cycle that the sender holds off
    int unsigned rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned cycles       = 0;

    positional_insert_remove_list #(.DEPTH(DEPTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t ERROR timeout, %0d results outstanding", $time,
                     mirror.due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver back-pressure; rx_stall_pct of zero keeps m_tready high.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Single monitor: inputs are noted before results are checked in the same
    // edge, and capacity writes reach the mirror at the edge they land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                mirror.set_capacity(cfg_wr_data);
            if (s_tvalid && s_tready)
                mirror.note_op(kind_t'(s_tuser), 32'(s_tdata[POS_W-1:0]),
                               s_tdata[POS_W +: VAL_W]);
            if (m_tvalid && m_tready)
                mirror.check_result({m_tuser[0], m_tdata[VAL_W-1:0],
                                     m_tdata[VAL_W +: LEN_W], m_tdata[VAL_W+LEN_W]});
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks. All return right after a rising edge, so each may follow
    // another without two assignments to s_tvalid in one step.
    // ------------------------------------------------------------------------

    // One operation transfer, preceded by a random hold-off.
    task automatic send_op(kind_t k, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= S_TDATA_W'({val, pos});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (mirror.due_results.size() != 0);
    endtask

    // Capacity is only changed with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] c);
        hold_until_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed positions near the current length; one in eight
    // spans the whole field. Values sometimes hit the signed extremes.
    task automatic random_op(int unsigned ins_pct);
        int unsigned      r;
        kind_t            k;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        r = $urandom_range(99);
        if (r == 0)
            k = KIND_CLEAR;
        else if (r <= ins_pct)
            k = KIND_INSERT;
        else if (r <= ins_pct + (99 - ins_pct) / 2)
            k = KIND_REMOVE;
        else
            k = KIND_READ;
        if ($urandom_range(7) == 0)
            pos = POS_W'($urandom_range(31));
        else
            pos = POS_W'($urandom_range(mirror.count + ((k == KIND_INSERT) ? 1 : 0)));
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0000_0000;
                default: val = 32'hFFFF_FFFF;
            endcase
        end else begin
            val = $urandom;
        end
        send_op(k, pos, val);
    endtask

    // One random phase: capacity, idle pattern, item count, insert share.
    // With pause set the sender also drains now and then, and once mid-phase.
    task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned tx_pct,
                             int unsigned rx_pct, int unsigned n_ops,
                             int unsigned ins_pct, bit pause);
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int unsigned i = 0; i < n_ops; i++) begin
            random_op(ins_pct);
            if (pause && (i == n_ops / 2 || $urandom_range(49) == 0))
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        mirror = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every kind, rejections at each boundary.
        send_op(KIND_INSERT, 5'd0,  32'h7FFF_FFFF);
        send_op(KIND_INSERT, 5'd0,  32'h8000_0000);   // prepend shifts up
        send_op(KIND_INSERT, 5'd2,  32'hFFFF_FFFF);   // append at count
        send_op(KIND_INSERT, 5'd5,  32'h0000_0001);   // past the end
        send_op(KIND_INSERT, 5'd31, 32'h0000_0002);   // far past the end
        send_op(KIND_READ,   5'd0,  32'h0);
        send_op(KIND_READ,   5'd2,  32'h0);
        send_op(KIND_READ,   5'd3,  32'h0);           // just out of range
        send_op(KIND_READ,   5'd31, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE, 5'd31, 32'h0);
        send_op(KIND_REMOVE, 5'd1,  32'h0);           // middle, shifts down
        send_op(KIND_READ,   5'd1,  32'h0);
        send_op(KIND_CLEAR,  5'd0,  32'h0);
        send_op(KIND_READ,   5'd0,  32'h0);           // empty list
        send_op(KIND_REMOVE, 5'd0,  32'h0);           // empty list

        // full list at a small capacity
        write_capacity(5'd2);
        send_op(KIND_INSERT, 5'd0, 32'h1234_5678);
        send_op(KIND_INSERT, 5'd1, 32'h8765_4321);
        send_op(KIND_INSERT, 5'd0, 32'hDEAD_BEEF);    // full

        // capacity lowered below the current length
        write_capacity(5'd1);
        send_op(KIND_INSERT, 5'd0, 32'h0BAD_F00D);    // over the new limit
        send_op(KIND_REMOVE, 5'd1, 32'h0);
        send_op(KIND_INSERT, 5'd0, 32'h0BAD_F00D);    // still at the limit
        send_op(KIND_REMOVE, 5'd0, 32'h0);
        send_op(KIND_INSERT, 5'd0, 32'hCAFE_0001);

        // Random phases over capacities and idle/stall patterns.
        run_phase(5'd16,  0,  0, 160, 55, 1'b0);
        run_phase(5'd31, 54,  0, 140, 55, 1'b0);   // above store size
        run_phase(5'd5,   0, 54, 100, 45, 1'b1);   // lowered below length
        run_phase(5'd0,  14, 14,  60, 50, 1'b0);   // nothing fits
        run_phase(5'd1,  54, 54,  60, 45, 1'b0);
        run_phase(5'd16, 14, 14, 180, 50, 1'b1);

        hold_until_drained();
        repeat (10) @(posedge aclk);

        $display("Covered %0d operations under capacities 0, 1, 2, 5, 16, 31;",
                 mirror.taken);
        $display("%0d results checked; inserts taken %0d, rejected %0d;",
                 mirror.checked, mirror.ins_ok, mirror.ins_rej);
        $display("longest list %0d; full flag seen %0d times.",
                 mirror.peak, mirror.full_hits);
        if (mirror.mismatches > 10)
            $display("%0d mismatches in total", mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pirl_pkg.sv
hw/rtl/pirl_ctrl.sv
hw/rtl/pirl_dpath.sv
hw/rtl/positional_insert_remove_list.sv
test/positional_insert_remove_list_tb.sv
